// ===== hdl/sas_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sas_pkg;

    // Set geometry
    localparam int CAPACITY = 32;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // Operation selected by an input item
    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_QUERY  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_PRESENT = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_MISSING = 3'd3,
        STAT_EMPTY   = 3'd4
    } status_t;

    // Per-cycle command to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [VAL_W-1:0]   value;
    } cell_ctl_t;

    // What the row reports back to control
    typedef struct packed {
        logic               hit;
        logic [VAL_W-1:0]   head;
    } chain_stat_t;

    // Control states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/sas_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sas_cell (
    input  logic                       clk,
    input  sas_pkg::cell_ctl_t         ctl,
    input  logic                       valid,     // cell lies below the fill count
    input  logic                       tail,      // cell is the last occupied one
    input  logic                       prev_lt,   // left neighbor holds a value below the key
    input  logic [sas_pkg::VAL_W-1:0]  prev_val,
    input  logic [sas_pkg::VAL_W-1:0]  next_val,
    input  logic [sas_pkg::VAL_W-1:0]  head_val,
    output logic [sas_pkg::VAL_W-1:0]  val,
    output logic                       lt,
    output logic                       eq
);
    import sas_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    // Compare against the broadcast key
    assign lt  = valid && (val_reg < ctl.value);
    assign eq  = valid && (val_reg == ctl.value);
    assign val = val_reg;

    // Shift decision: cells below the insertion or deletion point hold; rotate moves every cell
    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (!lt)
                begin
                    val_next = prev_lt ? ctl.value : prev_val;
                end
            end
            CELL_DELETE:
            begin
                if (!lt)
                begin
                    val_next = next_val;
                end
            end
            CELL_ROTATE:
            begin
                val_next = tail ? head_val : next_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

// ===== hdl/sas_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sas_chain (
    input  logic                       clk,
    input  sas_pkg::cell_ctl_t         ctl,
    input  logic [sas_pkg::CNT_W-1:0]  count,
    output sas_pkg::chain_stat_t       stat
);
    import sas_pkg::*;

    logic [VAL_W-1:0] val_w [CAPACITY];
    logic [CAPACITY-1:0] lt_w;
    logic [CAPACITY-1:0] eq_w;

    // Row of compare-and-shift cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic             valid_w;
        logic             tail_w;
        logic             prev_lt_w;
        logic [VAL_W-1:0] prev_val_w;
        logic [VAL_W-1:0] next_val_w;

        assign valid_w = (CNT_W'(i) < count);
        assign tail_w  = (CNT_W'(i + 1) == count);

        if (i == 0)
        begin : g_first
            assign prev_lt_w  = 1'b1;
            assign prev_val_w = ctl.value;
        end
        else
        begin : g_mid
            assign prev_lt_w  = lt_w[i-1];
            assign prev_val_w = val_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_val_w = val_w[0];
        end
        else
        begin : g_inner
            assign next_val_w = val_w[i+1];
        end

        sas_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .valid    (valid_w),
            .tail     (tail_w),
            .prev_lt  (prev_lt_w),
            .prev_val (prev_val_w),
            .next_val (next_val_w),
            .head_val (val_w[0]),
            .val      (val_w[i]),
            .lt       (lt_w[i]),
            .eq       (eq_w[i])
        );
    end

    assign stat.hit  = |eq_w;
    assign stat.head = val_w[0];

endmodule

`default_nettype wire

// ===== hdl/sorted_unique_set_top.sv =====
// Sorted set of up to 32 distinct 32-bit values, kept ascending in a row of
// compare-and-shift cells. The operation arrives on s_tuser: insert, delete,
// query, read out all, clear; other codes are taken and dropped with no
// result. Insert, delete, query and clear each give one result; the next
// item is taken once that result has left the output register or is being
// taken. Read-out gives one result per stored value in ascending order, one
// per cycle while the output is not stalled, by rotating the row through
// its head cell; the row is back in order when it ends. An empty read-out
// gives one result with status empty. Every result carries the count after
// its operation, and m_tlast marks the final result of an item.
`timescale 1ns / 1ps
`default_nettype none

module sorted_unique_set_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] found, [32:1] value_out, [38:33] count, [39] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast
);
    import sas_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              mvalid_reg, mvalid_next;
    status_t           status_reg, status_next;
    logic              found_reg, found_next;
    logic [VAL_W-1:0]  vout_reg, vout_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              last_reg, last_next;

    cell_ctl_t         ctl;
    chain_stat_t       cstat;
    logic              out_free;
    logic              accept;
    logic              load;
    logic [CNT_W-1:0]  cnt_m1;
    logic              read_last;

    sas_chain u_chain (
        .clk   (clk),
        .ctl   (ctl),
        .count (count_reg),
        .stat  (cstat)
    );

    assign out_free  = !mvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign read_last = (idx_reg == cnt_m1[IDX_W-1:0]);

    // Control: decode item, drive the row, fill the output register
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        ctl.op      = CELL_HOLD;
        ctl.value   = s_tdata[VAL_W-1:0];
        load        = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        vout_next   = vout_reg;
        ocnt_next   = ocnt_reg;
        last_next   = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    vout_next   = '0;
                    last_next   = 1'b1;
                    case (mode_t'(s_tuser))
                        MODE_INSERT:
                        begin
                            load = 1'b1;
                            if (cstat.hit)
                            begin
                                status_next = STAT_PRESENT;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctl.op     = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_DELETE:
                        begin
                            load = 1'b1;
                            if (cstat.hit)
                            begin
                                ctl.op     = CELL_DELETE;
                                count_next = cnt_m1;
                            end
                            else
                            begin
                                status_next = STAT_MISSING;
                            end
                        end
                        MODE_QUERY:
                        begin
                            load       = 1'b1;
                            found_next = cstat.hit;
                        end
                        MODE_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                load        = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_READ;
                                idx_next   = '0;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            load       = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                    ocnt_next = count_next;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    ctl.op      = CELL_ROTATE;
                    load        = 1'b1;
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    vout_next   = cstat.head;
                    ocnt_next   = count_reg;
                    last_next   = read_last;
                    idx_next    = idx_reg + IDX_W'(1);
                    if (read_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : mvalid_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        vout_reg   <= vout_next;
        ocnt_reg   <= ocnt_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {1'b0, ocnt_reg, vout_reg, found_reg};

endmodule

`default_nettype wire

// ===== hdl/sas_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sas_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast
);
    import sas_pkg::*;

    // Held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Count never exceeds capacity
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[38:33] <= 6'(CAPACITY)))
        else $error("count above capacity");

    // Empty read-out is a single final result with zero count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_EMPTY) |-> m_tlast && (m_tdata[38:33] == '0))
        else $error("bad empty result");

    // Full only when the set is at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[38:33] == 6'(CAPACITY)))
        else $error("full reported below capacity");

    // A hit only comes with an ok status and a zero value field
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tuser == STAT_OK) && (m_tdata[32:1] == '0))
        else $error("found set on a wrong result");

endmodule

bind sorted_unique_set_top sas_checker u_sas_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
